// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SM4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SM4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sm4_pkg.sv -----
`default_nettype none

package sm4_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int WORD_W      = 32;
  localparam int CFG_IDX_W   = 3;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_RUN
  } sm4_state_t;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MODE = 3'd4;

  localparam word_t FK_TAB [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam word_t CK_TAB [32] = '{
    32'h00070e15, 32'h1c232a31, 32'h383f464d, 32'h545b6269,
    32'h70777e85, 32'h8c939aa1, 32'ha8afb6bd, 32'hc4cbd2d9,
    32'he0e7eef5, 32'hfc030a11, 32'h181f262d, 32'h343b4249,
    32'h50575e65, 32'h6c737a81, 32'h888f969d, 32'ha4abb2b9,
    32'hc0c7ced5, 32'hdce3eaf1, 32'hf8ff060d, 32'h141b2229,
    32'h30373e45, 32'h4c535a61, 32'h686f767d, 32'h848b9299,
    32'ha0a7aeb5, 32'hbcc3cad1, 32'hd8dfe6ed, 32'hf4fb0209,
    32'h10171e25, 32'h2c333a41, 32'h484f565d, 32'h646b7279
  };

  localparam logic [7:0] SBOX_TAB [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic word_t tau(input word_t v);
    return {SBOX_TAB[v[31:24]], SBOX_TAB[v[23:16]], SBOX_TAB[v[15:8]], SBOX_TAB[v[7:0]]};
  endfunction

  function automatic word_t rotl(input word_t v, input int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

endpackage

`default_nettype wire

// ----- sv/sm4_ifs.sv -----
`default_nettype none

interface sm4_in_if;
  logic                valid;
  logic                ready;
  sm4_pkg::word_t      in_word0;
  sm4_pkg::word_t      in_word1;
  sm4_pkg::word_t      in_word2;
  sm4_pkg::word_t      in_word3;
  modport source (output valid, in_word0, in_word1, in_word2, in_word3, input ready);
  modport sink   (input valid, in_word0, in_word1, in_word2, in_word3, output ready);
endinterface

interface sm4_out_if;
  logic                valid;
  logic                ready;
  sm4_pkg::word_t      out_word0;
  sm4_pkg::word_t      out_word1;
  sm4_pkg::word_t      out_word2;
  sm4_pkg::word_t      out_word3;
  modport source (output valid, out_word0, out_word1, out_word2, out_word3, input ready);
  modport sink   (input valid, out_word0, out_word1, out_word2, out_word3, output ready);
endinterface

interface sm4_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [sm4_pkg::CFG_IDX_W-1:0]      cfg_index;
  sm4_pkg::word_t                     cfg_data;
  modport source (output valid, cfg_index, cfg_data, input ready);
  modport sink   (input valid, cfg_index, cfg_data, output ready);
endinterface

`default_nettype wire

// ----- sv/sm4_block_cipher_core.sv -----
`default_nettype none

// SM4 block cipher, ECB, one 128-bit block per beat as four 32-bit words. A block
// runs ROUND_COUNT (32) rounds, one per cycle, in a single shared round unit; the
// last round waits while the output register is still full, then the result is held
// there, and a new block may be accepted while that result waits. After reset and
// after every key word write the 32 round keys are re-expanded through the same
// round unit after a key load, taking no block meanwhile. cipher_mode 0 encrypts,
// 1 decrypts (round keys used in reverse order). Config writes are always accepted
// and belong to idle periods only; the user, not the core, must ensure it.
module sm4_block_cipher_core #(
  parameter int ROUND_COUNT = sm4_pkg::ROUND_COUNT
) (
  input  logic      clk,
  input  logic      rst_n,
  sm4_in_if.sink    in_if,
  sm4_out_if.source out_if,
  sm4_cfg_if.sink   cfg_if
);
  import sm4_pkg::*;

  localparam int CNT_W = $clog2(ROUND_COUNT);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ROUND_COUNT - 1);

  sm4_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             stale_r, stale_nxt;
  logic             mode_r, mode_nxt;
  word_t            key_r [4];
  word_t            key_nxt [4];
  word_t            w_r [4];
  word_t            w_nxt [4];
  word_t            out_w_r [4];
  word_t            out_w_nxt [4];
  logic             out_valid_r, out_valid_nxt;

  logic             in_acc;
  logic             cfg_acc;
  logic             key_we;
  logic             mode_we;
  logic [1:0]       key_sel;

  logic             ks_we;
  logic [CNT_W-1:0] rk_idx;
  word_t            rk;
  word_t            unit_k;
  word_t            unit_y;
  logic             is_expand;

  assign cfg_if.ready = 1'b1;
  assign cfg_acc      = cfg_if.valid & cfg_if.ready;
  assign in_if.ready  = (state_r == ST_IDLE) & ~stale_r;
  assign in_acc       = in_if.valid & in_if.ready;

  // register decode
  always_comb begin
    key_we  = 1'b0;
    mode_we = 1'b0;
    key_sel = 2'd0;
    unique case (cfg_if.cfg_index)
      CFG_KEY_WORD0: begin
        key_we  = cfg_acc;
        key_sel = 2'd0;
      end
      CFG_KEY_WORD1: begin
        key_we  = cfg_acc;
        key_sel = 2'd1;
      end
      CFG_KEY_WORD2: begin
        key_we  = cfg_acc;
        key_sel = 2'd2;
      end
      CFG_KEY_WORD3: begin
        key_we  = cfg_acc;
        key_sel = 2'd3;
      end
      CFG_CIPHER_MODE: mode_we = cfg_acc;
      default: ;
    endcase
  end

  assign is_expand = (state_r == ST_EXPAND);
  // round key is read through the registered key store from the next round count, so it is ready when that round runs
  assign rk_idx    = mode_r ? (LAST - cnt_nxt) : cnt_nxt;
  assign unit_k    = is_expand ? CK_TAB[cnt_r] : rk;

  sm4_key_store #(
    .DEPTH (ROUND_COUNT),
    .AW    (CNT_W)
  ) u_key_store (
    .clk   (clk),
    .we    (ks_we),
    .waddr (cnt_r),
    .wdata (unit_y),
    .raddr (rk_idx),
    .rdata (rk)
  );

  sm4_round_unit u_round (
    .a         (w_r[0]),
    .b         (w_r[1]),
    .c         (w_r[2]),
    .d         (w_r[3]),
    .k         (unit_k),
    .key_sched (is_expand),
    .y         (unit_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      stale_r     <= 1'b1;
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stale_r     <= stale_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= key_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      w_r[i]     <= w_nxt[i];
      out_w_r[i] <= out_w_nxt[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    stale_nxt     = stale_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r;
    ks_we         = 1'b0;
    for (int i = 0; i < 4; i++) begin
      key_nxt[i]   = key_r[i];
      w_nxt[i]     = w_r[i];
      out_w_nxt[i] = out_w_r[i];
    end

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (stale_r) begin
          for (int i = 0; i < 4; i++) begin
            w_nxt[i] = key_r[i] ^ FK_TAB[i];
          end
          cnt_nxt   = '0;
          stale_nxt = 1'b0;
          state_nxt = ST_EXPAND;
        end else if (in_acc) begin
          w_nxt[0]  = in_if.in_word0;
          w_nxt[1]  = in_if.in_word1;
          w_nxt[2]  = in_if.in_word2;
          w_nxt[3]  = in_if.in_word3;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_EXPAND: begin
        ks_we    = 1'b1;
        w_nxt[0] = w_r[1];
        w_nxt[1] = w_r[2];
        w_nxt[2] = w_r[3];
        w_nxt[3] = unit_y;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (cnt_r != LAST) begin
          w_nxt[0] = w_r[1];
          w_nxt[1] = w_r[2];
          w_nxt[2] = w_r[3];
          w_nxt[3] = unit_y;
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!out_valid_r || out_if.ready) begin
          // final round lands straight in the output register, words reversed
          out_w_nxt[0]  = unit_y;
          out_w_nxt[1]  = w_r[3];
          out_w_nxt[2]  = w_r[2];
          out_w_nxt[3]  = w_r[1];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a key write restarts expansion from the new key, after any block in progress finishes
    if (key_we) begin
      key_nxt[key_sel] = cfg_if.cfg_data;
      stale_nxt        = 1'b1;
      if (state_r != ST_RUN) begin
        state_nxt = ST_IDLE;
      end
    end
    if (mode_we) begin
      mode_nxt = cfg_if.cfg_data[0];
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_word0 = out_w_r[0];
  assign out_if.out_word1 = out_w_r[1];
  assign out_if.out_word2 = out_w_r[2];
  assign out_if.out_word3 = out_w_r[3];

  `include "assert_macros.svh"

  `SM4_ASSERT_NEXT(a_start_run, in_acc, (state_r == ST_RUN) && (cnt_r == '0), "block did not start at round zero")
  `SM4_ASSERT_NEXT(a_key_blocks_in, key_we, !in_if.ready, "block accepted on stale round keys")
  `SM4_ASSERT_NEXT(a_expand_done, is_expand && (cnt_r == LAST) && !key_we, (state_r == ST_IDLE) && !stale_r, "expansion did not finish cleanly")
  `SM4_ASSERT_NEXT(a_run_done, (state_r == ST_RUN) && (cnt_r == LAST) && (!out_valid_r || out_if.ready), out_valid_r && (state_r == ST_IDLE), "finished block not presented")

endmodule

`default_nettype wire

// ----- sv/sm4_round_unit.sv -----
`default_nettype none

// shared round unit: a ^ L(tau(b ^ c ^ d ^ k)), L picked by key_sched
module sm4_round_unit (
  input  sm4_pkg::word_t a,
  input  sm4_pkg::word_t b,
  input  sm4_pkg::word_t c,
  input  sm4_pkg::word_t d,
  input  sm4_pkg::word_t k,
  input  logic           key_sched,
  output sm4_pkg::word_t y
);
  import sm4_pkg::*;

  word_t t;
  word_t lin;

  always_comb begin
    t = tau(b ^ c ^ d ^ k);
    if (key_sched) begin
      lin = t ^ rotl(t, 13) ^ rotl(t, 23);
    end else begin
      lin = t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
    end
    y = a ^ lin;
  end

endmodule

`default_nettype wire

// ----- sv/sm4_key_store.sv -----
`default_nettype none

module sm4_key_store #(
  parameter int DEPTH = sm4_pkg::ROUND_COUNT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  sm4_pkg::word_t wdata,
  input  logic [AW-1:0]  raddr,
  output sm4_pkg::word_t rdata
);
  import sm4_pkg::*;

  word_t rk_r [DEPTH];
  word_t rdata_r;

  // registered read, data for raddr shows up the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      rk_r[waddr] <= wdata;
    end
    rdata_r <= rk_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
